/* hdl/cers_pkg.sv */
// ----------------------------------------------------------------------------
// cers_pkg
// Shared constants and types of the column extent to row span converter.
// ----------------------------------------------------------------------------
package cers_pkg;

  // Rows in the plane and field widths.
  localparam int ROWS      = 64;
  localparam int ROW_W     = 6;
  localparam int TOP_W     = 7;
  localparam int COL_W     = 11;
  localparam int XOUT_W    = 10;
  localparam int BUF_DEPTH = 2;

  // Row positions that may step one past either end of the plane.
  typedef logic signed [7:0] row_idx_t;
  localparam row_idx_t ROW_LAST = row_idx_t'(ROWS - 1);

  // Access to the row start memory for one cycle.
  typedef struct packed {
    logic             re;
    logic [ROW_W-1:0] raddr;
    logic             we;
    logic [ROW_W-1:0] waddr;
    logic [COL_W-1:0] wdata;
  } ram_req_t;

  // Span fields that travel alongside a pending memory read.
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [XOUT_W-1:0] last_x;
    logic              last;
  } span_meta_t;

  // Output buffer status seen by the sequencer.
  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } buf_stat_t;

endpackage

/* hdl/cers_col_if.sv */
// ----------------------------------------------------------------------------
// cers_col_if
// Column channel: one column extent pair per transfer.
// ----------------------------------------------------------------------------
interface cers_col_if;
  logic                      valid;
  logic                      ready;
  logic [cers_pkg::COL_W-1:0] column_x;
  logic [cers_pkg::TOP_W-1:0] prev_top;
  logic [cers_pkg::ROW_W-1:0] prev_bottom;
  logic [cers_pkg::TOP_W-1:0] cur_top;
  logic [cers_pkg::ROW_W-1:0] cur_bottom;

  modport source (
    output valid, column_x, prev_top, prev_bottom, cur_top, cur_bottom,
    input  ready
  );
  modport sink (
    input  valid, column_x, prev_top, prev_bottom, cur_top, cur_bottom,
    output ready
  );
endinterface

/* hdl/cers_span_if.sv */
// ----------------------------------------------------------------------------
// cers_span_if
// Span channel: one finished row span per transfer.
// ----------------------------------------------------------------------------
interface cers_span_if;
  logic                        valid;
  logic                        ready;
  logic [cers_pkg::ROW_W-1:0]  span_row;
  logic [cers_pkg::XOUT_W-1:0] span_first_x;
  logic [cers_pkg::XOUT_W-1:0] span_last_x;
  logic                        last_span;

  modport source (
    output valid, span_row, span_first_x, span_last_x, last_span,
    input  ready
  );
  modport sink (
    input  valid, span_row, span_first_x, span_last_x, last_span,
    output ready
  );
endinterface

/* hdl/cers_start_ram.sv */
// ----------------------------------------------------------------------------
// cers_start_ram
// Row start memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cers_start_ram (
  input  logic                       clk_i,
  input  cers_pkg::ram_req_t         req_i,
  output logic [cers_pkg::COL_W-1:0] rdata_o
);

  logic [cers_pkg::COL_W-1:0] mem [cers_pkg::ROWS];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule

/* hdl/cers_seq.sv */
// ----------------------------------------------------------------------------
// cers_seq
// Row sequencer: walks closing rows (reads) and opening rows (writes).
// ----------------------------------------------------------------------------
module cers_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cers_col_if.sink             col_i,
  input  cers_pkg::buf_stat_t  buf_stat_i,
  output cers_pkg::ram_req_t   ram_req_o,
  output logic                 meta_valid_o,
  output cers_pkg::span_meta_t meta_o
);

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_CLOSE_TOP = 5'b00010,
    ST_CLOSE_BOT = 5'b00100,
    ST_OPEN_TOP  = 5'b01000,
    ST_OPEN_BOT  = 5'b10000
  } seq_state_e;

  seq_state_e                 state_q, state_d;
  logic [cers_pkg::COL_W-1:0] x_q, x_d;
  cers_pkg::row_idx_t         t1_q, t1_d, b1_q, b1_d, t2_q, t2_d, b2_q, b2_d;
  cers_pkg::row_idx_t         t1_inc, b1_dec;
  cers_pkg::span_meta_t       meta_q, meta_d;
  logic                       pending_q;
  logic [2:0]                 occupancy;
  logic                       issue_ok;

  // Bottoms beyond the plane are pulled back to its last row.
  function automatic cers_pkg::row_idx_t clamp_bottom(input logic [cers_pkg::ROW_W-1:0] b);
    cers_pkg::row_idx_t v;
    v = cers_pkg::row_idx_t'({2'b00, b});
    if (v > cers_pkg::ROW_LAST) begin
      v = cers_pkg::ROW_LAST;
    end
    return v;
  endfunction

  assign col_i.ready  = (state_q == ST_IDLE);
  assign meta_valid_o = pending_q;
  assign meta_o       = meta_q;

  // A read may issue when the buffer has room for it after this cycle's pop.
  assign occupancy = 3'(buf_stat_i.count) + 3'(pending_q) - 3'(buf_stat_i.pop);
  assign issue_ok  = (occupancy < 3'(cers_pkg::BUF_DEPTH));

  assign t1_inc = t1_q + 8'sd1;
  assign b1_dec = b1_q - 8'sd1;

  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    t1_d      = t1_q;
    b1_d      = b1_q;
    t2_d      = t2_q;
    b2_d      = b2_q;
    meta_d    = meta_q;
    ram_req_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (col_i.valid) begin
          x_d     = col_i.column_x;
          t1_d    = cers_pkg::row_idx_t'({1'b0, col_i.prev_top});
          b1_d    = clamp_bottom(col_i.prev_bottom);
          t2_d    = cers_pkg::row_idx_t'({1'b0, col_i.cur_top});
          b2_d    = clamp_bottom(col_i.cur_bottom);
          state_d = ST_CLOSE_TOP;
        end
      end
      ST_CLOSE_TOP: begin
        if (t1_q < t2_q && t1_q <= b1_q) begin
          if (issue_ok) begin
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = t1_q[cers_pkg::ROW_W-1:0];
            meta_d.row      = t1_q[cers_pkg::ROW_W-1:0];
            meta_d.last_x   = x_q[cers_pkg::XOUT_W-1:0] - 10'd1;
            meta_d.last     = !((t1_inc < t2_q && t1_inc <= b1_q) ||
                                (b1_q > b2_q && b1_q >= t1_inc));
            t1_d            = t1_inc;
          end
        end else begin
          state_d = ST_CLOSE_BOT;
        end
      end
      ST_CLOSE_BOT: begin
        if (b1_q > b2_q && b1_q >= t1_q) begin
          if (issue_ok) begin
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = b1_q[cers_pkg::ROW_W-1:0];
            meta_d.row      = b1_q[cers_pkg::ROW_W-1:0];
            meta_d.last_x   = x_q[cers_pkg::XOUT_W-1:0] - 10'd1;
            meta_d.last     = !(b1_dec > b2_q && b1_dec >= t1_q);
            b1_d            = b1_dec;
          end
        end else begin
          state_d = ST_OPEN_TOP;
        end
      end
      ST_OPEN_TOP: begin
        if (t2_q < t1_q && t2_q <= b2_q) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = t2_q[cers_pkg::ROW_W-1:0];
          ram_req_o.wdata = x_q;
          t2_d            = t2_q + 8'sd1;
        end else begin
          state_d = ST_OPEN_BOT;
        end
      end
      ST_OPEN_BOT: begin
        if (b2_q > b1_q && b2_q >= t2_q) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = b2_q[cers_pkg::ROW_W-1:0];
          ram_req_o.wdata = x_q;
          b2_d            = b2_q - 8'sd1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pending_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pending_q <= ram_req_o.re;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    t1_q   <= t1_d;
    b1_q   <= b1_d;
    t2_q   <= t2_d;
    b2_q   <= b2_d;
    meta_q <= meta_d;
  end

endmodule

/* hdl/cers_out_buf.sv */
// ----------------------------------------------------------------------------
// cers_out_buf
// Two-entry span buffer between the memory read and the span channel.
// ----------------------------------------------------------------------------
module cers_out_buf (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  cers_pkg::span_meta_t       meta_i,
  input  logic [cers_pkg::COL_W-1:0] rdata_i,
  cers_span_if.source                span_o,
  output cers_pkg::buf_stat_t        stat_o
);

  typedef struct packed {
    logic [cers_pkg::ROW_W-1:0]  row;
    logic [cers_pkg::XOUT_W-1:0] first_x;
    logic [cers_pkg::XOUT_W-1:0] last_x;
    logic                        last;
  } span_entry_t;

  span_entry_t entry_q [cers_pkg::BUF_DEPTH];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        pop;

  assign span_o.valid        = (count_q != 2'd0);
  assign span_o.span_row     = entry_q[rd_ptr_q].row;
  assign span_o.span_first_x = entry_q[rd_ptr_q].first_x;
  assign span_o.span_last_x  = entry_q[rd_ptr_q].last_x;
  assign span_o.last_span    = entry_q[rd_ptr_q].last;

  assign pop          = span_o.valid && span_o.ready;
  assign stat_o.count = count_q;
  assign stat_o.pop   = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q].row     <= meta_i.row;
      entry_q[wr_ptr_q].first_x <= rdata_i[cers_pkg::XOUT_W-1:0];
      entry_q[wr_ptr_q].last_x  <= meta_i.last_x;
      entry_q[wr_ptr_q].last    <= meta_i.last;
    end
  end

endmodule

/* hdl/column_extent_to_row_spans.sv */
// ----------------------------------------------------------------------------
// column_extent_to_row_spans
// Converts per-column vertical extents of a plane into horizontal row spans.
// ----------------------------------------------------------------------------
// Usage: col_i takes one transfer per column: its x, the previous column's
// extent and the current column's extent (a top of 64 marks an empty one).
// A plane should begin with an empty column so that every row start is
// written before it is read. span_o gives one transfer per row that closes,
// first the rows closing at the top in increasing order, then those closing
// at the bottom in decreasing order; last_span marks the final span of a
// column. A column that closes no row gives no transfer.
// Sequencing: the sequencer steps one row of the start memory per cycle,
// holding a read while the span buffer has no room for it, first over the
// closed rows and then over the newly opened rows. The first span of a
// column is presented on span_o once its read data and span fields are
// registered and pushed into the buffer, later when only bottom rows close.
// col_i is ready only while the sequencer is idle.
// Reset clears the sequencer and the span buffer; the start memory is not
// cleared. When span_o stalls, at most two spans wait in the buffer and the
// sequencer holds the next read until space frees up.
// ----------------------------------------------------------------------------
module column_extent_to_row_spans (
  input  logic        clk_i,
  input  logic        rst_ni,
  cers_col_if.sink    col_i,
  cers_span_if.source span_o
);

  cers_pkg::ram_req_t         ram_req;
  logic [cers_pkg::COL_W-1:0] ram_rdata;
  logic                       meta_valid;
  cers_pkg::span_meta_t       meta;
  cers_pkg::buf_stat_t        buf_stat;

  // The sequencer walks the rows of each column and drives the memory.
  cers_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .col_i        (col_i),
    .buf_stat_i   (buf_stat),
    .ram_req_o    (ram_req),
    .meta_valid_o (meta_valid),
    .meta_o       (meta)
  );

  // Start column of each row, written as rows open and read as they close.
  cers_start_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // Read data joins its span fields in the cycle after the read is issued.
  cers_out_buf u_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (meta_valid),
    .meta_i  (meta),
    .rdata_i (ram_rdata),
    .span_o  (span_o),
    .stat_o  (buf_stat)
  );

endmodule
